### rtl/orws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orws_pkg: shared constants and types
// widths, command codes and result kinds of the rectangle weight sum block
// ----------------------------------------------------------------------------
package orws_pkg;
   localparam int MaxPointsDef  = 1024;
   localparam int MaxQueriesDef = 64;
   localparam int CoordBitsDef  = 16;
   localparam int SumBitsDef    = 40;
   localparam int QnumBits      = 6;

   typedef enum logic [1:0] {
      CMD_ADD_POINT = 2'd0,
      CMD_ADD_QUERY = 2'd1,
      CMD_CLEAR     = 2'd2,
      CMD_PROCESS   = 2'd3
   } command_type;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_FULL   = 1'b1;
endpackage
`default_nettype wire

### rtl/orws_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orws_req_if / orws_rsp_if: valid/ready channels
// one word per handshake on each channel
// ----------------------------------------------------------------------------
interface orws_req_if #(parameter int COORD_BITS = orws_pkg::CoordBitsDef);
   logic                       valid;
   logic                       ready;
   logic [1:0]                 command;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   logic signed [COORD_BITS-1:0] weight;
   logic signed [COORD_BITS-1:0] left;
   logic signed [COORD_BITS-1:0] bottom;
   logic signed [COORD_BITS-1:0] right;
   logic signed [COORD_BITS-1:0] top;
   modport source (output valid, command, px, py, weight, left, bottom, right, top,
                   input ready);
   modport sink (input valid, command, px, py, weight, left, bottom, right, top,
                 output ready);
endinterface

interface orws_rsp_if #(parameter int SUM_BITS = orws_pkg::SumBitsDef);
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [orws_pkg::QnumBits-1:0]      query_number;
   logic signed [SUM_BITS-1:0]         total;
   logic                               last;
   modport source (output valid, kind, query_number, total, last, input ready);
   modport sink (input valid, kind, query_number, total, last, output ready);
endinterface
`default_nettype wire

### rtl/orws_point_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orws_point_mem: point store
// simple dual port synchronous memory of (x, y, weight); read data is registered, adding latency
// ----------------------------------------------------------------------------
module orws_point_mem #(
   parameter int MAX_POINTS = orws_pkg::MaxPointsDef,
   parameter int COORD_BITS = orws_pkg::CoordBitsDef,
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int DW = 3 * COORD_BITS
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/orws_query_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orws_query_mem: query store
// simple dual port synchronous memory of rectangles; read data is registered, adding latency
// ----------------------------------------------------------------------------
module orws_query_mem #(
   parameter int MAX_QUERIES = orws_pkg::MaxQueriesDef,
   parameter int COORD_BITS  = orws_pkg::CoordBitsDef,
   localparam int AW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1,
   localparam int DW = 4 * COORD_BITS
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [MAX_QUERIES];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/offline_rectangle_weight_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// offline_rectangle_weight_sum: offline rectangle weight sum
// stores points and query rectangles, answers all queries on a process word
// ----------------------------------------------------------------------------
// add point / add query / clear: accepted while idle with no response pending,
// so words stream back to back; an overflowing word raises the full status word via ST_FULL
// process: per query the single point memory read port walks every stored point
// (ST_QREAD, ST_PREAD, ST_SCAN, ST_EMIT); answers leave in load order
// reset clears both fill counts and the control state; stores are not swept
// ----------------------------------------------------------------------------
module offline_rectangle_weight_sum #(
   parameter int MAX_POINTS  = orws_pkg::MaxPointsDef,
   parameter int MAX_QUERIES = orws_pkg::MaxQueriesDef,
   parameter int COORD_BITS  = orws_pkg::CoordBitsDef,
   parameter int SUM_BITS    = orws_pkg::SumBitsDef
) (
   input wire logic    clock,
   input wire logic    reset,
   orws_req_if.sink    req,
   orws_rsp_if.source  rsp
);
   localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int QAW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int QCW = $clog2(MAX_QUERIES + 1);
   localparam int CB  = COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_QREAD, ST_PREAD, ST_SCAN, ST_EMIT, ST_FULL
   } state_type;

   state_type             state_ff;
   logic [PCW-1:0]        pcount_ff;
   logic [QCW-1:0]        qcount_ff;
   logic [QCW-1:0]        qidx_ff;     // query under work
   logic [PCW-1:0]        pidx_ff;     // point address being read
   logic                  pvalid_ff;   // read data of the point memory is live
   logic                  qok_ff;
   logic signed [CB-1:0]  ql_ff, qb_ff, qr_ff, qt_ff;
   logic [SUM_BITS-1:0]   acc_ff;
   logic                  rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [orws_pkg::QnumBits-1:0] rsp_qnum_ff;
   logic [SUM_BITS-1:0]   rsp_total_ff;

   logic          p_wr, q_wr;
   logic [PAW-1:0] p_addr;
   logic [QAW-1:0] q_addr;
   logic [3*CB-1:0] p_rd;
   logic [4*CB-1:0] q_rd;
   logic          accept;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   assign p_wr = accept && (req.command == orws_pkg::CMD_ADD_POINT)
                 && (pcount_ff < PCW'(MAX_POINTS));
   assign q_wr = accept && (req.command == orws_pkg::CMD_ADD_QUERY)
                 && (qcount_ff < QCW'(MAX_QUERIES));
   // write at the fill count, otherwise walk the read pointers
   assign p_addr = p_wr ? pcount_ff[PAW-1:0] : pidx_ff[PAW-1:0];
   assign q_addr = q_wr ? qcount_ff[QAW-1:0] : qidx_ff[QAW-1:0];

   orws_point_mem #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_pmem (
      .clock(clock), .wr_en(p_wr), .wr_addr(p_addr),
      .wr_data({req.px[CB-1:0], req.py[CB-1:0], req.weight[CB-1:0]}),
      .rd_addr(p_addr), .rd_data(p_rd));

   orws_query_mem #(.MAX_QUERIES(MAX_QUERIES), .COORD_BITS(COORD_BITS)) u_qmem (
      .clock(clock), .wr_en(q_wr), .wr_addr(q_addr),
      .wr_data({req.left[CB-1:0], req.bottom[CB-1:0], req.right[CB-1:0],
                req.top[CB-1:0]}),
      .rd_addr(q_addr), .rd_data(q_rd));

   // point fields and the inclusion test
   logic signed [CB-1:0] px_w, py_w, pw_w;
   logic hit_w;
   assign px_w = p_rd[3*CB-1:2*CB];
   assign py_w = p_rd[2*CB-1:CB];
   assign pw_w = p_rd[CB-1:0];
   assign hit_w = (px_w >= ql_ff) && (px_w <= qr_ff) && (py_w >= qb_ff) && (py_w <= qt_ff);

   logic [QCW-1:0] qnext;
   assign qnext = qidx_ff + QCW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= '0;
         qcount_ff    <= '0;
         qidx_ff      <= '0;
         pidx_ff      <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req.command)
                     orws_pkg::CMD_ADD_POINT: begin
                        if (p_wr) pcount_ff <= pcount_ff + PCW'(1);
                        else state_ff <= ST_FULL;
                     end
                     orws_pkg::CMD_ADD_QUERY: begin
                        if (q_wr) qcount_ff <= qcount_ff + QCW'(1);
                        else state_ff <= ST_FULL;
                     end
                     orws_pkg::CMD_CLEAR: begin
                        pcount_ff <= '0;
                        qcount_ff <= '0;
                     end
                     default: begin
                        qidx_ff <= '0;
                        if (qcount_ff != '0) state_ff <= ST_QREAD;
                     end
                  endcase
               end
            end
            ST_FULL: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= orws_pkg::KIND_FULL;
               rsp_qnum_ff  <= '0;
               rsp_total_ff <= '0;
               rsp_last_ff  <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_QREAD: begin
               // query word is being read this cycle
               pidx_ff  <= '0;
               state_ff <= ST_PREAD;
            end
            ST_PREAD: begin
               ql_ff  <= q_rd[4*CB-1:3*CB];
               qb_ff  <= q_rd[3*CB-1:2*CB];
               qr_ff  <= q_rd[2*CB-1:CB];
               qt_ff  <= q_rd[CB-1:0];
               qok_ff <= ($signed(q_rd[4*CB-1:3*CB]) <= $signed(q_rd[2*CB-1:CB])) &&
                         ($signed(q_rd[3*CB-1:2*CB]) <= $signed(q_rd[CB-1:0]));
               acc_ff <= '0;
               pvalid_ff <= (pcount_ff != '0);
               pidx_ff   <= PCW'(1);
               state_ff  <= ST_SCAN;
            end
            ST_SCAN: begin
               // one point per cycle; the point memory read is issued ahead of its use
               if (pvalid_ff) begin
                  if (hit_w && qok_ff)
                     acc_ff <= acc_ff + SUM_BITS'(pw_w);
                  pvalid_ff <= (pidx_ff < pcount_ff);
                  pidx_ff   <= pidx_ff + PCW'(1);
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= orws_pkg::KIND_ANSWER;
                  rsp_qnum_ff  <= orws_pkg::QnumBits'(qidx_ff);
                  rsp_total_ff <= acc_ff;
                  rsp_last_ff  <= (qnext == qcount_ff);
                  qidx_ff      <= qnext;
                  state_ff     <= (qnext == qcount_ff) ? ST_IDLE : ST_QREAD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_kind_ff;
   assign rsp.query_number = rsp_qnum_ff;
   assign rsp.total        = rsp_total_ff;
   assign rsp.last         = rsp_last_ff;
endmodule
`default_nettype wire
